// File: sv/s2d_pkg.sv
// Shared types, constants and helpers for the signed binary to decimal text converter.
package s2d_pkg;

    // Default word width and fixed character widths
    localparam int WORD_BITS_DEF = 32;
    localparam int CHAR_BITS     = 8;
    localparam int BCD_BITS      = 4;

    // ASCII codes for the emitted characters
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'h2D;

    // Decimal digits needed for a magnitude of up to 2**(w-1): ceil(w * log10(2))
    function automatic int dec_digits(input int w);
        return (w * 30103 + 99999) / 100000;
    endfunction

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic neg;
        logic conv_done;
        logic top_zero;
        logic last_digit;
        logic out_free;
    } sts_t;

endpackage

// File: sv/s2d_ctrl.sv
// Controller state machine: sequences load, conversion, sign, zero skip and digit emission.
module s2d_ctrl
    import s2d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (sts.conv_done)
                begin
                    state_next = sts.neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(sts.top_zero && !sts.last_digit) && sts.out_free)
                begin
                    state_next = sts.last_digit ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            ST_SKIP:
            begin
                if (sts.top_zero && !sts.last_digit)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.emit_digit = sts.out_free;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Take a request only when idle
    assign in_stall = (state_reg != ST_IDLE);

    // One command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    // Conversion done always leads to sign or skip
    a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT) && sts.conv_done |=>
            (state_reg == ST_SIGN) || (state_reg == ST_SKIP))
        else $error("conversion did not hand over to emission");

    // A load only happens when the input side is not stalled
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !in_stall && in_valid)
        else $error("load without an accepted request");

endmodule

// File: sv/s2d_datapath.sv
// Datapath: magnitude shift register, shift-add-3 BCD register, counters and output register.
module s2d_datapath
    import s2d_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WORD_BITS-1:0] bit_pattern,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHAR_BITS-1:0] text_char,
    output logic                 last_char
);

    localparam int DIGITS    = dec_digits(WORD_BITS);
    localparam int BCD_W     = DIGITS * BCD_BITS;
    localparam int BIT_CNT_W = $clog2(WORD_BITS);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic                 neg_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAR_BITS-1:0] text_char_reg;
    logic                 last_char_reg;
    logic [BCD_BITS-1:0]  top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: BCD_BITS];

    // Add three to every BCD digit of five or more
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*BCD_BITS +: BCD_BITS] >= BCD_BITS'(5))
            begin
                bcd_adj[i*BCD_BITS +: BCD_BITS] =
                    bcd_reg[i*BCD_BITS +: BCD_BITS] + BCD_BITS'(3);
            end
        end
    end

    // Select next magnitude, BCD and counter values
    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load)
        begin
            mag_next     = bit_pattern[WORD_BITS-1] ? (~bit_pattern + 1'b1) : bit_pattern;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = DIG_CNT_W'(DIGITS);
        end
        else if (cmd.shift)
        begin
            mag_next     = {mag_reg[WORD_BITS-2:0], 1'b0};
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[WORD_BITS-1]};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-BCD_BITS-1:0], {BCD_BITS{1'b0}}};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
    end

    // Drop the output request once taken, raise it on a new character
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        if (cmd.load)
        begin
            neg_reg <= bit_pattern[WORD_BITS-1];
        end
        if (cmd.emit_sign)
        begin
            text_char_reg <= ASCII_MINUS;
            last_char_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            text_char_reg <= ASCII_ZERO + CHAR_BITS'(top_digit);
            last_char_reg <= (dig_cnt_reg == DIG_CNT_W'(1));
        end
    end

    // Report status
    always_comb
    begin
        sts.neg        = neg_reg;
        sts.conv_done  = (bit_cnt_reg == BIT_CNT_W'(WORD_BITS - 1));
        sts.top_zero   = (top_digit == '0);
        sts.last_digit = (dig_cnt_reg == DIG_CNT_W'(1));
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign text_char = text_char_reg;
    assign last_char = last_char_reg;

    // A character is only loaded when the output register is free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || !out_stall))
        else $error("character loaded over a pending result");

    // A leading zero skip never consumes the final digit
    a_skip_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.skip |-> (dig_cnt_reg > DIG_CNT_W'(1)))
        else $error("skip removed the last digit");

    // The final character is always a decimal digit
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_char_reg |->
            (text_char_reg >= ASCII_ZERO) && (text_char_reg <= ASCII_NINE))
        else $error("final character is not a digit");

    // Emitted digits stay within decimal range
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> (top_digit <= BCD_BITS'(9)))
        else $error("BCD digit out of range");

endmodule

// File: sv/signed_int_to_decimal_ascii_top.sv
// Sequence: accept the word, run the shift-add-3 BCD conversion over all WORD_BITS bits, then emit '-' if negative.
// Each of the dec_digits(WORD_BITS) digit positions is then skipped as a leading zero or emitted.
// A word is converted by the bit-serial BCD conversion loop and leaves at one character per cycle
// at the output while out_stall is low, and only one word is in flight at a time.
// A new word is taken as soon as the final character sits in the output register.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops out_valid.
module signed_int_to_decimal_ascii_top
    import s2d_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] bit_pattern,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHAR_BITS-1:0] text_char,
    output logic                 last_char
);

    cmd_t cmd;
    sts_t sts;

    // Sequence the conversion
    s2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Convert and emit characters
    s2d_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .bit_pattern (bit_pattern),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .text_char   (text_char),
        .last_char   (last_char)
    );

endmodule
